// File: design/crc64_msb_first_stream_core_macros.svh
// ----------------------------------------------------------------------------
// crc64_msb_first_stream_core_macros
// Assertion macros shared by the CRC-64 stream core.
// ----------------------------------------------------------------------------
`ifndef CRC64_MSB_FIRST_STREAM_CORE_MACROS_SVH
`define CRC64_MSB_FIRST_STREAM_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define CRC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: design/crc64ms_pkg.sv
// ----------------------------------------------------------------------------
// crc64ms_pkg
// Types, constants and the byte fold of the MSB-first CRC-64 stream core.
// ----------------------------------------------------------------------------
package crc64ms_pkg;

    localparam int unsigned CRC_W  = 64;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CRC_W-1:0] CRC_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY     = 64'h42F0_E1EB_A9EA_3693;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
    } t_in_word;

    // XOR the byte into the top bits, then eight shift/conditional-XOR steps.
    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] v;
        v = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int b = 0; b < BYTE_W; b++) begin
            if (v[CRC_W-1]) begin
                v = {v[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[CRC_W-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: design/crc64ms_in_reg.sv
// ----------------------------------------------------------------------------
// crc64ms_in_reg
// Input register: captures one byte word and holds it until the fold takes it.
// ----------------------------------------------------------------------------
module crc64ms_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  crc64ms_pkg::t_in_word i_word,
    input  logic                  i_adv,
    output logic                  o_valid,
    output crc64ms_pkg::t_in_word o_word
);

    logic                  r_valid;
    crc64ms_pkg::t_in_word r_word;

    // Take a new word when empty or when the held word moves on this cycle.
    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: design/crc64ms_fold_stage.sv
// ----------------------------------------------------------------------------
// crc64ms_fold_stage
// CRC register and result register: folds one byte per advance and loads
// the finished CRC on the last byte of a message.
// ----------------------------------------------------------------------------
`include "crc64_msb_first_stream_core_macros.svh"

module crc64ms_fold_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  crc64ms_pkg::t_in_word              i_word,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [crc64ms_pkg::CRC_W-1:0]      o_out_crc,
    output logic                               o_room
);

    logic                          r_out_valid;
    logic [crc64ms_pkg::CRC_W-1:0] r_out_crc;
    logic [crc64ms_pkg::CRC_W-1:0] r_crc;
    logic [crc64ms_pkg::CRC_W-1:0] n_crc;
    logic [crc64ms_pkg::CRC_W-1:0] w_base;

    assign w_base = i_word.first ? crc64ms_pkg::CRC_ALL_ONES : r_crc;
    assign n_crc  = crc64ms_pkg::fold_byte(w_base, i_word.data);

    // Result slot is free now or drains this cycle.
    assign o_room = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= crc64ms_pkg::CRC_ALL_ONES;
        end else if (i_adv) begin
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv && i_word.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_word.last) begin
            r_out_crc <= n_crc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_crc   = r_out_crc;

    `CRC_ASSERT(a_last_loads_result, (i_adv && i_word.last) |=> (r_out_valid && r_out_crc == r_crc), "result does not match CRC register")
    `CRC_ASSERT(a_crc_holds_idle, !i_adv |=> $stable(r_crc), "CRC register moved without a byte")
    `CRC_ASSERT(a_result_from_last, $rose(r_out_valid) |-> $past(i_adv && i_word.last), "result appeared without a last byte")
    `CRC_ASSERT_NEVER(a_no_overwrite, i_adv && i_word.last && r_out_valid && !i_out_ready, "pending result overwritten")

endmodule

// File: design/crc64_msb_first_stream_core.sv
// A byte accepted into the input register is folded into the CRC register as
// it advances; a last byte also loads the result register, whose CRC is shown
// on m_axis until taken. Throughput: one byte per cycle while a last byte finds
// the result slot free, set by the combinational eight-step fold from input to CRC register.
// Reset (synchronous, active low): CRC register to all ones, both stages empty.
// ----------------------------------------------------------------------------
// crc64_msb_first_stream_core
// MSB-first CRC-64 (poly 0x42F0E1EBA9EA3693, init all ones, no final XOR)
// over a byte stream; tuser marks the first byte, tlast the last byte.
// ----------------------------------------------------------------------------
module crc64_msb_first_stream_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] first_byte
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // [63:0] crc_value
);

    crc64ms_pkg::t_in_word w_in_word;
    crc64ms_pkg::t_in_word w_held_word;
    logic                  w_held_valid;
    logic                  w_room;
    logic                  w_adv;

    assign w_in_word.data  = s_axis_tdata;
    assign w_in_word.first = s_axis_tuser;
    assign w_in_word.last  = s_axis_tlast;

    // Advance a held word; a last word also needs the result slot.
    assign w_adv = w_held_valid && (!w_held_word.last || w_room);

    crc64ms_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (w_in_word),
        .i_adv   (w_adv),
        .o_valid (w_held_valid),
        .o_word  (w_held_word)
    );

    crc64ms_fold_stage u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_word      (w_held_word),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_crc   (m_axis_tdata),
        .o_room      (w_room)
    );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MSB-first CRC-64 stream core: bytes go in on
// s_axis with tuser as the first-byte mark and tlast as the last-byte mark;
// every CRC taken on m_axis is checked against a software fold of the same
// bytes. Both sides idle at random, apart from one stretch with no gaps.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS = 830;

    class crc_tracker;
        logic [crc64ms_pkg::CRC_W-1:0] crc_state;
        logic [crc64ms_pkg::CRC_W-1:0] pending_crcs[$];
        int unsigned                   fails;

        function new();
            crc_state = crc64ms_pkg::CRC_ALL_ONES;
            fails = 0;
        endfunction

        function logic [crc64ms_pkg::CRC_W-1:0] crc_fold(
            logic [crc64ms_pkg::CRC_W-1:0]  r,
            logic [crc64ms_pkg::BYTE_W-1:0] d
        );
            r = r ^ {d, {(crc64ms_pkg::CRC_W-crc64ms_pkg::BYTE_W){1'b0}}};
            repeat (crc64ms_pkg::BYTE_W) begin
                if (r[crc64ms_pkg::CRC_W-1]) begin
                    r = {r[crc64ms_pkg::CRC_W-2:0], 1'b0} ^ crc64ms_pkg::CRC_POLY;
                end else begin
                    r = {r[crc64ms_pkg::CRC_W-2:0], 1'b0};
                end
            end
            return r;
        endfunction

        // Note an accepted input word.
        function void fold_in(logic [crc64ms_pkg::BYTE_W-1:0] d, logic first, logic last);
            crc_state = crc_fold(first ? crc64ms_pkg::CRC_ALL_ONES : crc_state, d);
            if (last) begin
                pending_crcs.push_back(crc_state);
            end
        endfunction

        // Check a CRC word taken from the output.
        function void check_crc(logic [crc64ms_pkg::CRC_W-1:0] actual);
            logic [crc64ms_pkg::CRC_W-1:0] want;
            if (pending_crcs.size() == 0) begin
                $display("%0t: CRC with no message pending: expected none, actual %h",
                         $time, actual);
                fails++;
            end else begin
                want = pending_crcs.pop_front();
                if (want !== actual) begin
                    $display("%0t: crc_value mismatch: expected %h, actual %h",
                             $time, want, actual);
                    fails++;
                end
            end
        endfunction

        function int unsigned pending();
            return pending_crcs.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] first_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] crc_value

    crc_tracker  tracker;
    bit          steady_run;
    int unsigned bytes_sent;
    int unsigned stall_cycles;

    crc64_msb_first_stream_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(logic [7:0] d, logic first, logic last);
        while (!steady_run && $urandom_range(99) < 26) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        s_axis_tuser  = first;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.fold_in(d, first, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Well-formed message, or noise with random marks.
    task automatic send_message(int unsigned len, bit noisy);
        logic first;
        logic last;
        for (int unsigned i = 0; i < len; i++) begin
            first = noisy ? logic'($urandom_range(1)) : logic'(i == 0);
            last  = noisy ? logic'($urandom_range(3) == 0) : logic'(i == len - 1);
            send_byte(8'($urandom_range(255)), first, last);
        end
    endtask

    // Output side: random backpressure, sample at the rising edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = steady_run || ($urandom_range(99) >= 26);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                tracker.check_crc(m_axis_tdata);
            end
        end
    end

    // Stop when neither side moves a word for too long.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int unsigned len;
        tracker       = new();
        steady_run    = 1'b0;
        bytes_sent    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Unmarked start right after reset relies on the reset value.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // One-byte messages at the byte extremes.
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h80, 1'b1, 1'b1);
        send_byte(8'h01, 1'b1, 1'b1);
        // Unmarked byte after a finished message folds on from the emitted CRC.
        send_byte(8'h5A, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b1);
        // Nine-byte ASCII check string.
        for (int i = 0; i < 9; i++) begin
            send_byte(8'h31 + 8'(i), logic'(i == 0), logic'(i == 8));
        end
        // First mark in the middle of an open message restarts it.
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h56, 1'b1, 1'b1);

        while (bytes_sent < RANDOM_ITEMS + 21) begin
            steady_run = (bytes_sent >= 400) && (bytes_sent < 560);
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            send_message(len, $urandom_range(9) == 0);
        end
        steady_run = 1'b0;
        s_axis_tvalid = 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (tracker.fails == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
